/* design/polyphonic_sine_adsr_synth_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef POLYPHONIC_SINE_ADSR_SYNTH_ASSERT_SVH
`define POLYPHONIC_SINE_ADSR_SYNTH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSAS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psas assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psas assertion failed");

`endif

/* design/psas_pkg.sv */
`timescale 1ns / 1ps
package psas_pkg;

  localparam int VOICES_DEF     = 10;
  localparam int SINE_BITS_DEF  = 10;
  localparam int TIME_BITS_DEF  = 24;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int ACC_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_HZ_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;

  localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  localparam logic [15:0] FULL_SCALE = 16'h8000;
  localparam logic [31:0] SIN_A = 32'd51472;
  localparam logic [31:0] SIN_B = 32'd21024;
  localparam logic [31:0] SIN_C = 32'd2320;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DATA, ST_PHASE, ST_MUL, ST_DIV,
    ST_MIXA, ST_MIXB, ST_ACC, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    ENV_HOLD, ENV_ATTACK, ENV_DECAY, ENV_REL, ENV_FREE
  } env_t;

  // Polynomial quarter-wave sine in Q1.15, z is the Q15 fraction of the quarter.
  function automatic logic [15:0] quarter_sine(input logic [31:0] z);
    logic [31:0] z2;
    logic [31:0] t;
    z2 = (z * z) >> 15;
    t  = (SIN_C * z2) >> 15;
    t  = SIN_B - t;
    t  = (t * z2) >> 15;
    t  = SIN_A - t;
    t  = (t * z) >> 15;
    return (t > 32'd32767) ? 16'd32767 : t[15:0];
  endfunction

endpackage

/* design/psas_ram.sv */
`timescale 1ns / 1ps
module psas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/psas_sine.sv */
`timescale 1ns / 1ps
module psas_sine #(
  parameter int TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               load,
  input  logic [31:0]        phase,
  output logic signed [15:0] sine
);
  import psas_pkg::*;

  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int JW      = TABLE_BITS - 1;

  // Quarter wave with both end points; the mirrored quadrants reach the top entry.
  logic [15:0] qtab [QUARTER+1];

  for (genvar j = 0; j <= QUARTER; j++) begin : g_tab
    assign qtab[j] = quarter_sine(32'(j) << (17 - TABLE_BITS));
  end

  logic [TABLE_BITS-1:0] idx;
  logic [1:0]            quad;
  logic [JW-1:0]         pos;
  logic [JW-1:0]         j_sel;
  logic [15:0]           mag;

  assign idx   = phase[31 -: TABLE_BITS];
  assign quad  = idx[TABLE_BITS-1 -: 2];
  assign pos   = {1'b0, idx[TABLE_BITS-3:0]};
  assign j_sel = quad[0] ? (JW'(QUARTER) - pos) : pos;
  assign mag   = qtab[j_sel];

  always_ff @(posedge clk) begin
    if (load) begin
      sine <= quad[1] ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

/* design/psas_div.sv */
`timescale 1ns / 1ps
module psas_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] num,
  input  logic [23:0] den,
  output logic        done,
  output logic [15:0] quo
);

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // num < den * 2^16, so the upper part of num already sits below den.
  logic [23:0] rem;
  logic [23:0] dsr;
  logic [15:0] shreg;
  logic [4:0]  cnt;
  logic        busy;
  logic [24:0] trial;
  logic        fits;

  assign trial = {rem, shreg[15]};
  assign fits  = (trial >= {1'b0, dsr});
  assign quo   = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[39:16];
      shreg <= num[15:0];
      dsr   <= den;
    end else if (busy) begin
      rem   <= fits ? 24'(trial - {1'b0, dsr}) : trial[23:0];
      shreg <= {shreg[14:0], fits};
    end
  end

endmodule

/* design/polyphonic_sine_adsr_synth.sv */
`timescale 1ns / 1ps
// Channel   Signals                                   Direction
// request   in_valid, in_ready, mode, note_number     in
// result    out_valid, out_ready, mixed_sample        out
// config    cfg_we, cfg_index, cfg_data               in
//
// Note-on and note-off requests read and inspect each voice they visit.
// A tick reads each voice; an active voice also passes the phase, mul, mix and
// accumulate states, and in attack, decay or release the bit-serial divider.
// Reset is synchronous; voice state needs no clearing pass.
// A waiting result stalls only the end of the next tick, not new requests.
module polyphonic_sine_adsr_synth #(
  parameter int VOICES          = psas_pkg::VOICES_DEF,
  parameter int SINE_TABLE_BITS = psas_pkg::SINE_BITS_DEF,
  parameter int TIME_BITS       = psas_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic [6:0]                     note_number,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [13:0]             mixed_sample,
  input  logic                           cfg_we,
  input  logic [psas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psas_pkg::CFG_W-1:0]     cfg_data
);
  import psas_pkg::*;

  localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int WW   = 55 + TIME_BITS;
  localparam int CMPW = ((TIME_BITS > CFG_W) ? TIME_BITS : CFG_W) + 1;
  localparam logic signed [9:0]  GAIN  = 10'sd500;
  localparam logic signed [47:0] ROUND = 48'sd1073741823;

  // Configuration. Zero durations act as one and sustain is clamped to full
  // scale, so those rules are applied once at write time.
  logic [CFG_W-1:0] hz_step, attack, decay, release_len;
  logic [15:0]      sustain;

  always_ff @(posedge clk) begin
    if (rst) begin
      hz_step     <= 24'd89478;
      attack      <= 24'd480;
      decay       <= 24'd4800;
      sustain     <= 16'd24576;
      release_len <= 24'd4800;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HZ_STEP: hz_step     <= cfg_data;
        REG_ATTACK:  attack      <= (cfg_data == '0) ? 24'd1 : cfg_data;
        REG_DECAY:   decay       <= (cfg_data == '0) ? 24'd1 : cfg_data;
        REG_SUSTAIN: sustain     <= (cfg_data[15:0] > FULL_SCALE) ? FULL_SCALE
                                                                  : cfg_data[15:0];
        REG_RELEASE: release_len <= (cfg_data == '0) ? 24'd1 : cfg_data;
        default: ;
      endcase
    end
  end

  // Per-voice flags live in flip-flops so that reset frees every voice at
  // once. The written bit masks RAM entries that were never stored, which
  // then read as zero, their reset value.
  logic [VOICES-1:0] gate, active, written;

  state_t state, state_next;
  logic [VW-1:0] vidx;
  logic          last_voice;
  logic [1:0]    cmd;
  logic [6:0]    cmd_note;

  // Voice memory word: phase, note, envelope time, envelope level.
  logic          ram_we;
  logic [WW-1:0] ram_wdata, ram_rdata, rd_word;
  logic [31:0]   rd_phase;
  logic [6:0]    rd_note;
  logic [15:0]   rd_level;

  psas_ram #(.WIDTH(WW), .DEPTH(VOICES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vidx),
    .wdata (ram_wdata),
    .raddr (vidx),
    .rdata (ram_rdata)
  );

  assign last_voice = (vidx == VW'(VOICES - 1));
  assign rd_word    = written[vidx] ? ram_rdata : '0;
  assign rd_phase   = rd_word[WW-1 -: 32];
  assign rd_note    = rd_word[WW-33 -: 7];
  assign rd_level   = rd_word[15:0];

  // Decisions made when a voice word arrives from memory.
  logic take_on, hit_off, tick_go;
  assign take_on = (cmd == MODE_NOTE_ON) && !active[vidx];
  assign hit_off = (cmd == MODE_NOTE_OFF) && gate[vidx] && active[vidx] &&
                   (rd_note == cmd_note);
  assign tick_go = (cmd == MODE_TICK) && active[vidx];

  // Working registers of the voice being ticked.
  logic [31:0]          cur_phase, phase_new;
  logic [6:0]           cur_note;
  logic [TIME_BITS-1:0] cur_time, time_inc;
  logic [15:0]          cur_level, level_new, e_val;
  logic [13:0]          freq;
  env_t                 env;
  logic [15:0]          mul_a;
  logic [23:0]          mul_b;
  logic signed [25:0]   p1;
  logic signed [42:0]   p2;
  logic signed [ACC_W-1:0] acc;

  logic [37:0] step_prod;
  assign step_prod = freq * hz_step;
  assign time_inc  = (cur_time == '1) ? cur_time : cur_time + 1'b1;

  // Envelope segment selection against the time before this tick.
  logic [CMPW-1:0] t_x, a_x, ad_x, r_x, t_minus_a, r_minus_t;
  assign t_x       = CMPW'(cur_time);
  assign a_x       = CMPW'(attack);
  assign ad_x      = CMPW'(attack) + CMPW'(decay);
  assign r_x       = CMPW'(release_len);
  assign t_minus_a = t_x - a_x;
  assign r_minus_t = r_x - t_x;

  // Envelope divider: numerator from the registered operands, divisor by segment.
  logic        div_start, div_done;
  logic [39:0] div_num;
  logic [23:0] div_den;
  logic [15:0] div_quo;

  assign div_num = mul_a * mul_b;
  always_comb begin
    case (env)
      ENV_ATTACK: div_den = attack;
      ENV_DECAY:  div_den = decay;
      default:    div_den = release_len;
    endcase
  end

  psas_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic               sine_load;
  logic signed [15:0] sine;

  psas_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine (
    .clk   (clk),
    .load  (sine_load),
    .phase (phase_new),
    .sine  (sine)
  );

  // Exact truncation toward zero of (acc * 2^30 + p2) / 2^30.
  logic signed [47:0] total, total_adj;
  assign total     = (48'(acc) <<< 30) + 48'(p2);
  assign total_adj = total[47] ? total + ROUND : total;

  // Next state. Each voice is read, changed and written back before the next
  // one is read, so read and write of one entry never overlap.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid && mode != MODE_UNUSED) state_next = ST_READ;
      ST_READ:  state_next = ST_DATA;
      ST_DATA: begin
        if (take_on) begin
          state_next = ST_IDLE;
        end else if (tick_go) begin
          state_next = ST_PHASE;
        end else if (last_voice) begin
          state_next = (cmd == MODE_TICK) ? ST_OUT : ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_PHASE: state_next = ST_MUL;
      ST_MUL:   state_next = (env inside {ENV_ATTACK, ENV_DECAY, ENV_REL}) ? ST_DIV
                                                                          : ST_MIXA;
      ST_DIV:   if (div_done) state_next = ST_MIXA;
      ST_MIXA:  state_next = ST_MIXB;
      ST_MIXB:  state_next = ST_ACC;
      ST_ACC:   state_next = last_voice ? ST_OUT : ST_READ;
      ST_OUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = {rd_phase, rd_note, {TIME_BITS{1'b0}}, rd_level};
    div_start = 1'b0;
    sine_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DATA: begin
        if (take_on) begin
          ram_we    = 1'b1;
          ram_wdata = {rd_phase, cmd_note, {TIME_BITS{1'b0}}, rd_level};
        end else if (hit_off) begin
          ram_we = 1'b1;
        end
      end
      ST_MUL: begin
        sine_load = 1'b1;
        div_start = (env inside {ENV_ATTACK, ENV_DECAY, ENV_REL});
      end
      ST_ACC: begin
        ram_we    = 1'b1;
        ram_wdata = {phase_new, cur_note, time_inc, level_new};
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gate      <= '0;
      active    <= '0;
      written   <= '0;
      vidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        vidx <= '0;
      end else if (state_next == ST_READ) begin
        vidx <= vidx + 1'b1;
      end
      if (state == ST_DATA && take_on) begin
        gate[vidx]    <= 1'b1;
        active[vidx]  <= 1'b1;
        written[vidx] <= 1'b1;
      end
      if (state == ST_DATA && hit_off) begin
        gate[vidx] <= 1'b0;
      end
      if (state == ST_ACC && env == ENV_FREE) begin
        active[vidx] <= 1'b0;
      end
      // A new result replaces an accepted one in the same cycle.
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd      <= mode;
        cmd_note <= note_number;
        acc      <= '0;
      end
      ST_DATA: begin
        cur_phase <= rd_phase;
        cur_note  <= rd_note;
        cur_time  <= rd_word[16 +: TIME_BITS];
        cur_level <= rd_level;
        freq      <= 14'(rd_note) * 14'd100 + 14'd300;
      end
      ST_PHASE: begin
        phase_new <= cur_phase + step_prod[31:0];
        if (gate[vidx]) begin
          if (t_x > ad_x) begin
            env       <= ENV_HOLD;
            e_val     <= sustain;
            level_new <= sustain;
          end else if (t_x > a_x) begin
            env   <= ENV_DECAY;
            mul_a <= FULL_SCALE - sustain;
            mul_b <= t_minus_a[CFG_W-1:0];
          end else begin
            env   <= ENV_ATTACK;
            mul_a <= FULL_SCALE;
            mul_b <= t_x[CFG_W-1:0];
          end
        end else if (t_x > r_x) begin
          env       <= ENV_FREE;
          e_val     <= '0;
          level_new <= '0;
        end else begin
          env       <= ENV_REL;
          mul_a     <= cur_level;
          mul_b     <= r_minus_t[CFG_W-1:0];
          level_new <= cur_level;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          case (env)
            ENV_ATTACK: begin
              e_val     <= div_quo;
              level_new <= div_quo;
            end
            ENV_DECAY: begin
              e_val     <= FULL_SCALE - div_quo;
              level_new <= FULL_SCALE - div_quo;
            end
            default: e_val <= div_quo;
          endcase
        end
      end
      ST_MIXA: p1 <= GAIN * sine;
      ST_MIXB: p2 <= p1 * $signed({1'b0, e_val});
      ST_ACC:  acc <= total_adj[ACC_W+29:30];
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          if (acc > 17'sd8191) begin
            mixed_sample <= 14'sd8191;
          end else if (acc < -17'sd8192) begin
            mixed_sample <= -14'sd8192;
          end else begin
            mixed_sample <= acc[13:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/psas_checker.sv */
`timescale 1ns / 1ps
`include "polyphonic_sine_adsr_synth_assert.svh"
module psas_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        mode,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [13:0] mixed_sample
);
  import psas_pkg::*;

  // A waiting result stays offered.
  `PSAS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // A waiting result keeps its value.
  `PSAS_ASSERT_SAME(a_out_stable, clk, rst, $past(out_valid && !out_ready), $stable(mixed_sample))

  // Any real request keeps the block busy for the next cycle.
  `PSAS_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready && mode != MODE_UNUSED, !in_ready)

  // No result can appear in the cycle right after a request is taken.
  `PSAS_ASSERT_NEXT(a_no_early_out, clk, rst, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind polyphonic_sine_adsr_synth psas_checker u_psas_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .mode         (mode),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .mixed_sample (mixed_sample)
);
